FILE: hdl/stl_pkg.sv
package stl_pkg;

	localparam int IdWidth    = 64;
	localparam int OwnerWidth = 31;
	localparam int LangWidth  = 4;
	localparam int TimeWidth  = 32;
	localparam int LimitWidth = 7;
	localparam int CfgWidth   = 32;
	localparam int CfgAddrWidth = 2;

	typedef enum logic [2:0] {
		FN_LOGIN   = 3'd0,
		FN_LOGOUT  = 3'd1,
		FN_DESTROY = 3'd2,
		FN_GET_OWN = 3'd3,
		FN_GET_LNG = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOTAL    = 3'd1,
		ST_OWNER    = 3'd2,
		ST_COLLIDE  = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [CfgAddrWidth-1:0] {
		CFG_TOTAL_LIMIT  = 2'd0,
		CFG_OWNER_LIMIT  = 2'd1,
		CFG_IDLE_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic [IdWidth-1:0]    id;
		logic [OwnerWidth-1:0] owner;
		logic [LangWidth-1:0]  lang;
		logic [TimeWidth-1:0]  last_use;
	} slot_t;

endpackage

FILE: hdl/session_table_with_limits.sv
// Session table: SESSION_SLOTS entries kept in one single-port-write memory with a
// registered read. Every operation (login, logout, destroy owner, get owner, get
// language, and the unused codes) reads each slot once in order, one slot per cycle,
// updating the slot where the operation changes it; a login that passes its limit and
// collision checks then writes the new session into the lowest free slot in the done
// state, as its result is loaded into the output register. A new word is not accepted
// until the result of the last one has been loaded into the output register. After
// reset the block runs a clearing pass over every slot of the memory before s_tready
// first rises; configuration writes are taken at any time and must only be issued while the block is idle.
module session_table_with_limits import stl_pkg::*; #(
	parameter int SESSION_SLOTS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CfgAddrWidth-1:0] cfg_addr,
	input  logic [CfgWidth-1:0]     cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// session_id[63:0], owner_id[94:64], lang[98:95], now[130:99], zero pad
	input  logic [135:0]            s_tdata,
	// func[2:0]
	input  logic [2:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// owner_out[30:0], lang_out[34:31], zero pad
	output logic [39:0]             m_tdata,
	// status[2:0]
	output logic [2:0]              m_tuser
);

	localparam int AW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
	localparam int CW = $clog2(SESSION_SLOTS + 1);
	localparam int LW = (CW > LimitWidth) ? CW : LimitWidth;
	localparam logic [CW-1:0] SlotsC = CW'(SESSION_SLOTS);
	localparam logic [CW-1:0] LastC  = CW'(SESSION_SLOTS - 1);

	state_t state_q, state_d;

	logic [LimitWidth-1:0] total_limit_q, owner_limit_q;
	logic [TimeWidth-1:0]  idle_timeout_q;

	slot_t mem [SESSION_SLOTS];
	slot_t rd_data_q;

	logic [CW-1:0] ptr_q;
	logic          vld_s1;
	logic [AW-1:0] addr_s1;

	func_t                 op_func_q;
	logic [IdWidth-1:0]    op_id_q;
	logic [OwnerWidth-1:0] op_owner_q;
	logic [LangWidth-1:0]  op_lang_q;
	logic [TimeWidth-1:0]  op_now_q;

	logic [CW-1:0]         live_cnt_q, mine_cnt_q;
	logic                  free_found_q, found_q;
	logic [AW-1:0]         free_idx_q;
	logic [OwnerWidth-1:0] hit_owner_q;
	logic [LangWidth-1:0]  hit_lang_q;

	logic                  m_tvalid_q;
	status_t               status_q;
	logic [OwnerWidth-1:0] owner_out_q;
	logic [LangWidth-1:0]  lang_out_q;

	logic          accept, issue, out_free, scan_end;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	slot_t         mem_wdata;

	logic  expired, alive, id_hit, own_hit, slot_we;
	slot_t slot_upd;

	status_t               done_status;
	logic                  insert;
	logic [OwnerWidth-1:0] done_owner;
	logic [LangWidth-1:0]  done_lang;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign scan_end = (ptr_q == SlotsC) && !vld_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q  <= LimitWidth'(64);
			owner_limit_q  <= LimitWidth'(8);
			idle_timeout_q <= TimeWidth'(3600);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TOTAL_LIMIT:  total_limit_q  <= cfg_wdata[LimitWidth-1:0];
				CFG_OWNER_LIMIT:  owner_limit_q  <= cfg_wdata[LimitWidth-1:0];
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata[TimeWidth-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (ptr_q == LastC) state_d = S_IDLE;
			S_IDLE:  if (s_tvalid) state_d = S_SCAN;
			S_SCAN:  if (scan_end) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	// per-slot update of the word coming back from memory
	always_comb begin
		expired = rd_data_q.valid && (op_func_q == FN_LOGIN) &&
			(({1'b0, rd_data_q.last_use} + {1'b0, idle_timeout_q}) < {1'b0, op_now_q});
		alive   = rd_data_q.valid && !expired;
		id_hit  = alive && (rd_data_q.id == op_id_q);
		own_hit = alive && (rd_data_q.owner == op_owner_q);
		slot_upd = rd_data_q;
		slot_we  = 1'b0;
		case (op_func_q)
			FN_LOGIN: begin
				slot_upd.valid = 1'b0;
				slot_we = expired;
			end
			FN_LOGOUT: begin
				slot_upd.valid = 1'b0;
				slot_we = id_hit;
			end
			FN_DESTROY: begin
				slot_upd.valid = 1'b0;
				slot_we = own_hit;
			end
			FN_GET_OWN: begin
				slot_upd.last_use = op_now_q;
				slot_we = id_hit;
			end
			default: ;
		endcase
	end

	// verdict at the end of a scan
	always_comb begin
		done_status = ST_OK;
		insert      = 1'b0;
		done_owner  = '0;
		done_lang   = '0;
		case (op_func_q)
			FN_LOGIN: begin
				if (LW'(live_cnt_q) >= LW'(total_limit_q) || !free_found_q)
					done_status = ST_TOTAL;
				else if (LW'(mine_cnt_q) >= LW'(owner_limit_q))
					done_status = ST_OWNER;
				else if (found_q)
					done_status = ST_COLLIDE;
				else
					insert = 1'b1;
			end
			FN_GET_OWN: begin
				if (found_q) done_owner  = hit_owner_q;
				else         done_status = ST_NOTFOUND;
			end
			FN_GET_LNG: begin
				if (found_q) done_lang   = hit_lang_q;
				else         done_status = ST_NOTFOUND;
			end
			default: ;
		endcase
	end

	// control outputs and memory write port
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		issue     = (state_q == S_SCAN) && (ptr_q != SlotsC);
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = slot_upd;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wdata = '0;
			end
			S_SCAN: mem_we = vld_s1 && slot_we;
			S_DONE: begin
				mem_we    = out_free && insert;
				mem_waddr = free_idx_q;
				mem_wdata = '{valid: 1'b1, id: op_id_q, owner: op_owner_q,
					lang: op_lang_q, last_use: op_now_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (issue)  rd_data_q <= mem[ptr_q[AW-1:0]];
	end

	// scan pointer and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (accept)
				ptr_q <= '0;
			else if (state_q == S_CLEAR || issue)
				ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) addr_s1 <= ptr_q[AW-1:0];
	end

	// hold the word under work
	always_ff @(posedge clk) begin
		if (accept) begin
			op_func_q  <= func_t'(s_tuser);
			op_id_q    <= s_tdata[63:0];
			op_owner_q <= s_tdata[94:64];
			op_lang_q  <= s_tdata[98:95];
			op_now_q   <= s_tdata[130:99];
		end
	end

	// accumulate over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cnt_q   <= '0;
			mine_cnt_q   <= '0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
		end else if (accept) begin
			live_cnt_q   <= '0;
			mine_cnt_q   <= '0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
		end else if (state_q == S_SCAN && vld_s1) begin
			live_cnt_q <= live_cnt_q + CW'(alive);
			mine_cnt_q <= mine_cnt_q + CW'(own_hit);
			if (!alive) free_found_q <= 1'b1;
			if (id_hit) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && vld_s1) begin
			if (!alive && !free_found_q) free_idx_q <= addr_s1;
			if (id_hit) begin
				hit_owner_q <= rd_data_q.owner;
				hit_lang_q  <= rd_data_q.lang;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q    <= done_status;
			owner_out_q <= done_owner;
			lang_out_q  <= done_lang;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, lang_out_q, owner_out_q};
	assign m_tuser  = status_q;

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN))
		else $error("accepted word did not start a scan");

	a_live_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		live_cnt_q <= SlotsC)
		else $error("live count exceeds slot count");

	a_insert_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && insert) |-> free_found_q)
		else $error("insert without a free slot");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !$past(m_tvalid_q)) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the done step");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory written while idle");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import stl_pkg::*;

	localparam int SLOTS = 64;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int ID_POOL = 80;
	localparam int OWNER_POOL = 6;
	localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FN_SPARE_LAST = 3'd7;

	typedef struct {
		status_t               status;
		logic [OwnerWidth-1:0] owner;
		logic [LangWidth-1:0]  lang;
	} reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CfgAddrWidth-1:0] cfg_addr = '0;
	logic [CfgWidth-1:0]     cfg_wdata = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [135:0]            s_tdata = '0;
	logic [2:0]              s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [39:0]             m_tdata;
	logic [2:0]              m_tuser;

	session_table_with_limits #(.SESSION_SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// shadow of the session table and its limits
	logic                  sess_live  [SLOTS];
	logic [IdWidth-1:0]    sess_id    [SLOTS];
	logic [OwnerWidth-1:0] sess_owner [SLOTS];
	logic [LangWidth-1:0]  sess_lang  [SLOTS];
	logic [TimeWidth-1:0]  sess_stamp [SLOTS];
	logic [LimitWidth-1:0] lim_total = 7'd64;
	logic [LimitWidth-1:0] lim_owner = 7'd8;
	logic [TimeWidth-1:0]  idle_limit = 32'd3600;

	reply_t expected_replies [$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;
	int quiet_cycles = 0;
	logic [TimeWidth-1:0]  sim_now = '0;
	logic [IdWidth-1:0]    id_pool [ID_POOL];
	logic [OwnerWidth-1:0] owner_pool [OWNER_POOL];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			sess_live[i] = 1'b0;
		end
	end

	function automatic int find_session(logic [IdWidth-1:0] sid);
		for (int i = 0; i < SLOTS; i++) begin
			if (sess_live[i] && sess_id[i] == sid) return i;
		end
		return -1;
	endfunction

	function automatic reply_t predict_reply(logic [2:0] code, logic [IdWidth-1:0] sid,
			logic [OwnerWidth-1:0] own, logic [LangWidth-1:0] lng, logic [TimeWidth-1:0] at);
		reply_t r;
		int hit;
		int live_count;
		int mine;
		int free_slot;
		r.status = ST_OK;
		r.owner = '0;
		r.lang = '0;
		case (code)
			FN_LOGIN: begin
				// evict idle sessions first; the sum is taken in 33 bits
				for (int i = 0; i < SLOTS; i++) begin
					if (sess_live[i] && ({1'b0, sess_stamp[i]} + {1'b0, idle_limit}) < {1'b0, at})
						sess_live[i] = 1'b0;
				end
				live_count = 0;
				mine = 0;
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (sess_live[i]) begin
						live_count++;
						if (sess_owner[i] == own) mine++;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (live_count >= int'(lim_total) || free_slot < 0) begin
					r.status = ST_TOTAL;
				end else if (mine >= int'(lim_owner)) begin
					r.status = ST_OWNER;
				end else if (find_session(sid) >= 0) begin
					r.status = ST_COLLIDE;
				end else begin
					sess_live[free_slot] = 1'b1;
					sess_id[free_slot] = sid;
					sess_owner[free_slot] = own;
					sess_lang[free_slot] = lng;
					sess_stamp[free_slot] = at;
				end
			end
			FN_LOGOUT: begin
				hit = find_session(sid);
				if (hit >= 0) sess_live[hit] = 1'b0;
			end
			FN_DESTROY: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (sess_live[i] && sess_owner[i] == own) sess_live[i] = 1'b0;
				end
			end
			FN_GET_OWN: begin
				hit = find_session(sid);
				if (hit >= 0) begin
					r.owner = sess_owner[hit];
					sess_stamp[hit] = at;
				end else begin
					r.status = ST_NOTFOUND;
				end
			end
			FN_GET_LNG: begin
				hit = find_session(sid);
				if (hit >= 0) r.lang = sess_lang[hit];
				else r.status = ST_NOTFOUND;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [IdWidth-1:0] pick_id();
		if ($urandom_range(0, 99) < 10) return {$urandom, $urandom};
		return id_pool[$urandom_range(0, ID_POOL - 1)];
	endfunction

	function automatic logic [OwnerWidth-1:0] pick_owner();
		if ($urandom_range(0, 99) < 10) return OwnerWidth'($urandom);
		return owner_pool[$urandom_range(0, OWNER_POOL - 1)];
	endfunction

	// mostly small steps so sessions stay live, now and then a jump past the timeout
	function automatic logic [TimeWidth-1:0] next_time();
		int step_cap;
		if ($urandom_range(0, 99) < 3) return $urandom;
		if ($urandom_range(0, 99) < 4) begin
			if (idle_limit > 32'h1000_0000) sim_now += $urandom_range(1, 5000);
			else sim_now += idle_limit + $urandom_range(1, 500);
		end else begin
			step_cap = (idle_limit < 1000) ? int'(idle_limit) / 8 + 2 : 60;
			sim_now += $urandom_range(0, step_cap);
		end
		return sim_now;
	endfunction

	task automatic send_word(input logic [2:0] code, input logic [IdWidth-1:0] sid,
			input logic [OwnerWidth-1:0] own, input logic [LangWidth-1:0] lng,
			input logic [TimeWidth-1:0] at);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= code;
		s_tdata <= {5'b0, at, lng, own, sid};
		do @(posedge clk); while (!s_tready);
		expected_replies.push_back(predict_reply(code, sid, own, lng, at));
	endtask

	task automatic pause_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain_replies();
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CfgWidth-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_TOTAL_LIMIT:  lim_total = value[LimitWidth-1:0];
			CFG_OWNER_LIMIT:  lim_owner = value[LimitWidth-1:0];
			CFG_IDLE_TIMEOUT: idle_limit = value;
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [LimitWidth-1:0] tot, input logic [LimitWidth-1:0] own,
			input logic [TimeWidth-1:0] idle);
		pause_input();
		drain_replies();
		write_register(CFG_TOTAL_LIMIT, CfgWidth'(tot));
		write_register(CFG_OWNER_LIMIT, CfgWidth'(own));
		write_register(CFG_IDLE_TIMEOUT, idle);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_lookup_and_remove();
		send_word(FN_LOGIN, '0, '0, '0, 32'd0);
		send_word(FN_LOGIN, '1, '1, '1, 32'd100);
		send_word(FN_LOGIN, '1, 31'd5, 4'd3, 32'd100);
		send_word(FN_GET_OWN, '0, '1, '1, 32'd10);
		send_word(FN_GET_OWN, '1, '0, '0, 32'd100);
		send_word(FN_GET_LNG, '1, '0, '0, 32'd100);
		send_word(FN_GET_LNG, '0, '0, '0, 32'd100);
		send_word(FN_GET_OWN, 64'd12345, '0, '0, 32'd100);
		send_word(FN_GET_LNG, 64'd12345, '0, '0, 32'd100);
		send_word(FN_LOGOUT, 64'd12345, '0, '0, 32'd100);
		send_word(FN_DESTROY, '0, 31'd77, '0, 32'd100);
		for (int c = FN_SPARE_FIRST; c <= FN_SPARE_LAST; c++) begin
			send_word(3'(c), {$urandom, $urandom}, OwnerWidth'($urandom), LangWidth'($urandom),
				$urandom);
		end
		send_word(FN_LOGOUT, '1, '0, '0, 32'd100);
		send_word(FN_GET_LNG, '1, '0, '0, 32'd100);
	endtask

	task automatic test_idle_expiry();
		send_word(FN_LOGIN, 64'd5, 31'd9, 4'd2, 32'd1000);
		// 1000 + 3600 falls short of 4601: evict
		send_word(FN_LOGIN, 64'd6, 31'd9, 4'd7, 32'd4601);
		send_word(FN_GET_OWN, 64'd5, '0, '0, 32'd4601);
		// equal to the deadline: keep
		send_word(FN_LOGIN, 64'd8, 31'd9, 4'd1, 32'd8201);
		send_word(FN_GET_LNG, 64'd6, '0, '0, 32'd8201);
		sim_now = 32'd8201;
	endtask

	task automatic test_limit_extremes();
		configure(7'd0, 7'd8, 32'd3600);
		send_word(FN_LOGIN, 64'd9, 31'd4, 4'd0, 32'd8201);
		configure(7'd127, 7'd0, 32'd3600);
		send_word(FN_LOGIN, 64'd9, 31'd4, 4'd0, 32'd8201);
		configure(7'd127, 7'd1, '1);
		send_word(FN_LOGIN, 64'd10, 31'd3, 4'd5, 32'hFFFF_FFF0);
		send_word(FN_LOGIN, 64'd11, 31'd3, 4'd6, 32'hFFFF_FFFF);
		send_word(FN_DESTROY, '0, 31'd3, '0, 32'hFFFF_FFFF);
		send_word(FN_LOGIN, 64'd11, 31'd3, 4'd6, 32'hFFFF_FFFF);
	endtask

	// fill every slot, with the output held off at the start, then pause until all replies are in
	task automatic test_table_full();
		configure(7'd127, 7'd64, '1);
		recv_hold = HOLD_CYCLES;
		for (int i = 0; i < SLOTS + 6; i++) begin
			send_word(FN_LOGIN, {$urandom, $urandom}, pick_owner(), LangWidth'($urandom),
				next_time());
		end
		pause_input();
		drain_replies();
	endtask

	task automatic run_random_traffic(input int items);
		int r;
		logic [2:0] code;
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 38) code = FN_LOGIN;
			else if (r < 50) code = FN_LOGOUT;
			else if (r < 55) code = FN_DESTROY;
			else if (r < 76) code = FN_GET_OWN;
			else if (r < 97) code = FN_GET_LNG;
			else code = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
			send_word(code, pick_id(), pick_owner(), LangWidth'($urandom), next_time());
		end
	endtask

	initial begin
		for (int i = 0; i < ID_POOL; i++) id_pool[i] = {$urandom, $urandom};
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 0; i < OWNER_POOL; i++) owner_pool[i] = OwnerWidth'($urandom);
		owner_pool[0] = '0;
		owner_pool[1] = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_lookup_and_remove();
		test_idle_expiry();
		test_limit_extremes();
		test_table_full();

		recv_stall_pct = 68;
		run_random_traffic(360);

		configure(7'd64, 7'd8, 32'd3600);
		recv_stall_pct = 0;
		run_random_traffic(360);

		configure(7'd20, 7'd3, 32'd200);
		send_idle_pct = 68;
		run_random_traffic(360);

		configure(7'd64, 7'd1, 32'd0);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		run_random_traffic(300);

		pause_input();
		drain_replies();
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold = recv_hold - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected word status %0d owner %0h lang %0h", $time,
					m_tuser, m_tdata[30:0], m_tdata[34:31]);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[30:0] !== want.owner) begin
					$display("%0t: owner_out expected %0h actual %0h", $time, want.owner,
						m_tdata[30:0]);
					mismatch_count++;
				end
				if (m_tdata[34:31] !== want.lang) begin
					$display("%0t: lang_out expected %0h actual %0h", $time, want.lang,
						m_tdata[34:31]);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
